/* rtl/rai_pkg.sv */
// Shared types, widths and helpers of the ray versus axis-aligned rectangle test.
// No dependencies; every other file of the block imports this package.
package rai_pkg;

  localparam int unsigned CW       = 32;           // coordinate width
  localparam int unsigned FB       = 16;           // fraction bits
  localparam int unsigned NUM_W    = CW + FB + 1;  // magnitude of the t numerator
  localparam int unsigned T_W      = NUM_W + 1;    // signed quotient t
  localparam int unsigned PROD_W   = 2 * CW;
  localparam int unsigned PT_W     = 2 * CW - FB + 1; // exact hit coordinate
  localparam int unsigned SPAN_W   = CW + 1;
  localparam int unsigned TEX_BITS = 16;
  localparam int unsigned TEX_W    = TEX_BITS + 1;
  localparam int unsigned MAT_W    = 16;
  localparam int unsigned IDX_W    = 3;

  typedef enum logic [1:0] {
    AX_XY  = 2'd0,
    AX_XZ  = 2'd1,
    AX_YZ  = 2'd2,
    AX_BAD = 2'd3
  } axis_e;

  typedef enum logic [IDX_W-1:0] {
    CFG_AXIS     = 3'd0,
    CFG_OFFSET   = 3'd1,
    CFG_A_LOW    = 3'd2,
    CFG_A_HIGH   = 3'd3,
    CFG_B_LOW    = 3'd4,
    CFG_B_HIGH   = 3'd5,
    CFG_MATERIAL = 3'd6,
    CFG_NONE     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] origin_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
    logic signed [CW-1:0] t_lower;
    logic signed [CW-1:0] t_upper;
  } ray_in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] t_hit;
    logic [TEX_W-1:0]     tex_u;
    logic [TEX_W-1:0]     tex_v;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic [1:0]           normal_axis;
    logic [MAT_W-1:0]     hit_material;
  } hit_out_t;

  // Sideband that rides along the t divider
  typedef struct packed {
    logic [2:0][CW-1:0] org;
    logic [2:0][CW-1:0] dir;
    logic [CW-1:0]      tl;
    logic [CW-1:0]      tu;
    logic               qneg;
    logic               miss;
  } tdiv_side_t;

  // Sideband that rides along the texture dividers
  typedef struct packed {
    logic               miss;
    logic [CW-1:0]      t_hit;
    logic [2:0][CW-1:0] pt;
    logic               zero_a;
    logic               zero_b;
  } tex_side_t;

  function automatic logic [CW-1:0] sat_coord(logic signed [PT_W-1:0] v);
    logic signed [PT_W-1:0] mx;
    logic signed [PT_W-1:0] mn;
    mx = {{(PT_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
    mn = {{(PT_W-CW+1){1'b1}}, {(CW-1){1'b0}}};
    if (v > mx) begin
      sat_coord = {1'b0, {(CW-1){1'b1}}};
    end else if (v < mn) begin
      sat_coord = {1'b1, {(CW-1){1'b0}}};
    end else begin
      sat_coord = v[CW-1:0];
    end
  endfunction

endpackage

/* rtl/rai_tdiv.sv */
// Pipelined restoring divider for the plane-crossing parameter, one quotient bit per stage.
// Depends on rai_pkg.
module rai_tdiv (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [rai_pkg::NUM_W-1:0]  num_i,
  input  logic [rai_pkg::CW-1:0]     den_i,
  input  rai_pkg::tdiv_side_t        side_i,
  output logic                       valid_o,
  output logic [rai_pkg::NUM_W-1:0]  quot_o,
  output rai_pkg::tdiv_side_t        side_o
);
  import rai_pkg::*;

  localparam int unsigned NS = NUM_W;

  logic [NS-1:0]    vld_q;
  logic [CW-1:0]    rem_q  [NS];
  logic [NUM_W-1:0] num_q  [NS];
  logic [NUM_W-1:0] quo_q  [NS];
  logic [CW-1:0]    den_q  [NS];
  tdiv_side_t       side_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [CW-1:0]    rem_p;
    logic [CW-1:0]    den_p;
    logic [NUM_W-1:0] num_p;
    logic [NUM_W-1:0] quo_p;
    logic             v_p;
    tdiv_side_t       s_p;
    logic [CW:0]      trial;
    logic [CW:0]      diff;
    logic             take;
    logic [CW-1:0]    rem_d;
    logic [NUM_W-1:0] quo_d;

    if (k == 0) begin : g_first
      assign rem_p = '0;
      assign den_p = den_i;
      assign num_p = num_i;
      assign quo_p = '0;
      assign v_p   = valid_i;
      assign s_p   = side_i;
    end else begin : g_next
      assign rem_p = rem_q[k-1];
      assign den_p = den_q[k-1];
      assign num_p = num_q[k-1];
      assign quo_p = quo_q[k-1];
      assign v_p   = vld_q[k-1];
      assign s_p   = side_q[k-1];
    end

    assign trial = {rem_p, num_p[NUM_W-1-k]};
    assign diff  = trial - {1'b0, den_p};
    assign take  = trial >= {1'b0, den_p};

    always_comb begin
      rem_d = take ? diff[CW-1:0] : trial[CW-1:0];
      quo_d = quo_p;
      quo_d[NUM_W-1-k] = take;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        quo_q[k]  <= quo_d;
        num_q[k]  <= num_p;
        den_q[k]  <= den_p;
        side_q[k] <= s_p;
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign quot_o  = quo_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

/* rtl/rai_texdiv.sv */
// Two-lane pipelined divider for the texture coordinates, one quotient bit per stage.
// Depends on rai_pkg.
module rai_texdiv (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [1:0][rai_pkg::SPAN_W-1:0] x_i,
  input  logic [1:0][rai_pkg::SPAN_W-1:0] span_i,
  input  rai_pkg::tex_side_t          side_i,
  output logic                        valid_o,
  output logic [1:0][rai_pkg::TEX_W-1:0] quot_o,
  output rai_pkg::tex_side_t          side_o
);
  import rai_pkg::*;

  localparam int unsigned NS = TEX_W;

  logic [NS-1:0]                 vld_q;
  logic [1:0][SPAN_W-1:0]        rem_q  [NS];
  logic [1:0][SPAN_W-1:0]        span_q [NS];
  logic [1:0][TEX_W-1:0]         quo_q  [NS];
  tex_side_t                     side_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [1:0][SPAN_W-1:0] rem_p;
    logic [1:0][SPAN_W-1:0] span_p;
    logic [1:0][TEX_W-1:0]  quo_p;
    logic                   v_p;
    tex_side_t              s_p;
    logic [1:0][SPAN_W:0]   trial;
    logic [1:0][SPAN_W-1:0] rem_d;
    logic [1:0][TEX_W-1:0]  quo_d;

    if (k == 0) begin : g_first
      assign span_p = span_i;
      assign quo_p  = '0;
      assign v_p    = valid_i;
      assign s_p    = side_i;
      assign rem_p  = x_i;
      assign trial[0] = {1'b0, rem_p[0]};
      assign trial[1] = {1'b0, rem_p[1]};
    end else begin : g_next
      assign span_p = span_q[k-1];
      assign quo_p  = quo_q[k-1];
      assign v_p    = vld_q[k-1];
      assign s_p    = side_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign trial[0] = {rem_p[0], 1'b0};
      assign trial[1] = {rem_p[1], 1'b0};
    end

    always_comb begin
      quo_d = quo_p;
      for (int l = 0; l < 2; l++) begin
        if (trial[l] >= {1'b0, span_p[l]}) begin
          rem_d[l] = SPAN_W'(trial[l] - {1'b0, span_p[l]});
          quo_d[l][TEX_W-1-k] = 1'b1;
        end else begin
          rem_d[l] = trial[l][SPAN_W-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        span_q[k] <= span_p;
        quo_q[k]  <= quo_d;
        side_q[k] <= s_p;
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign quot_o  = quo_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

/* rtl/ray_axis_rectangle_intersect_unit.sv */
// Top level of the ray versus axis-aligned rectangle intersection pipeline.
// Depends on rai_pkg, rai_tdiv and rai_texdiv.
//
// One ray word goes in per cycle while the output is not stalled, and one result word comes
// out per ray, in order, after it passes the bit-per-stage divider that finds the
// plane-crossing t (the front-end setup is folded into its first stage), the register of
// the window test, the register of the three t*dir multipliers, the two-lane
// texture divider (its first stage also forms the hit point and the bound tests) and
// the output register. The whole pipe advances together whenever the output
// register is empty or being taken, so in_ready_o follows out_ready_i through that one
// term; a stall holds every stage and drops nothing. Results of a miss carry all-zero
// fields. Configuration registers are written through cfg_we_i at any edge and must only
// change while no ray is in flight; writes to an index past the material tag are dropped.
module ray_axis_rectangle_intersect_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rai_pkg::ray_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output rai_pkg::hit_out_t           out_data_o,
  input  logic                        cfg_we_i,
  input  logic [rai_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [rai_pkg::CW-1:0]      cfg_data_i
);
  import rai_pkg::*;

  // Configuration registers
  logic [1:0]       axis_q;
  logic [CW-1:0]    offset_q, a_low_q, a_high_q, b_low_q, b_high_q;
  logic [MAT_W-1:0] material_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q     <= AX_XY;
      offset_q   <= '0;
      a_low_q    <= '0;
      a_high_q   <= CW'(1) << FB;
      b_low_q    <= '0;
      b_high_q   <= CW'(1) << FB;
      material_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_AXIS:     axis_q     <= cfg_data_i[1:0];
        CFG_OFFSET:   offset_q   <= cfg_data_i;
        CFG_A_LOW:    a_low_q    <= cfg_data_i;
        CFG_A_HIGH:   a_high_q   <= cfg_data_i;
        CFG_B_LOW:    b_low_q    <= cfg_data_i;
        CFG_B_HIGH:   b_high_q   <= cfg_data_i;
        CFG_MATERIAL: material_q <= cfg_data_i[MAT_W-1:0];
        CFG_NONE:     ;
        default:      ;
      endcase
    end
  end

  // Whole-pipe advance: move when the output register is free or being drained
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Front end: pick the normal axis, form |num| = |off - o_n| << FB and |d_n|
  logic [2:0][CW-1:0] org_in, dir_in;
  logic [CW-1:0]      o_n, d_n;
  logic               bad_axis;
  logic [CW:0]        diff_n, absdiff;
  logic [CW-1:0]      absden;
  logic [NUM_W-1:0]   num_mag;
  tdiv_side_t         front_side;

  assign org_in = {in_data_i.origin_z, in_data_i.origin_y, in_data_i.origin_x};
  assign dir_in = {in_data_i.dir_z, in_data_i.dir_y, in_data_i.dir_x};

  always_comb begin
    bad_axis = 1'b0;
    unique case (axis_e'(axis_q))
      AX_XY: begin
        o_n = org_in[2];
        d_n = dir_in[2];
      end
      AX_XZ: begin
        o_n = org_in[1];
        d_n = dir_in[1];
      end
      AX_YZ: begin
        o_n = org_in[0];
        d_n = dir_in[0];
      end
      default: begin
        o_n      = org_in[0];
        d_n      = dir_in[0];
        bad_axis = 1'b1;
      end
    endcase
    diff_n  = {offset_q[CW-1], offset_q} - {o_n[CW-1], o_n};
    absdiff = diff_n[CW] ? (~diff_n + 1'b1) : diff_n;
    absden  = d_n[CW-1] ? (~d_n + 1'b1) : d_n;
    num_mag = {absdiff, {FB{1'b0}}};
    front_side.org  = org_in;
    front_side.dir  = dir_in;
    front_side.tl   = in_data_i.t_lower;
    front_side.tu   = in_data_i.t_upper;
    front_side.qneg = diff_n[CW] ^ d_n[CW-1];
    front_side.miss = bad_axis || (d_n == '0);
  end

  logic             tdiv_valid;
  logic [NUM_W-1:0] tdiv_quot;
  tdiv_side_t       tdiv_side;

  rai_tdiv u_tdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i && in_ready_o),
    .num_i   (num_mag),
    .den_i   (absden),
    .side_i  (front_side),
    .valid_o (tdiv_valid),
    .quot_o  (tdiv_quot),
    .side_o  (tdiv_side)
  );

  // Window stage: sign the quotient and test it against [t_lower, t_upper]
  logic signed [T_W-1:0] t_full, tl_ext, tu_ext;
  logic                  win_miss;

  always_comb begin
    t_full   = tdiv_side.qneg ? -$signed({1'b0, tdiv_quot}) : $signed({1'b0, tdiv_quot});
    tl_ext   = T_W'($signed(tdiv_side.tl));
    tu_ext   = T_W'($signed(tdiv_side.tu));
    win_miss = tdiv_side.miss || (t_full < tl_ext) || (t_full > tu_ext);
  end

  logic               w_valid_q;
  logic [CW-1:0]      w_t_q;
  logic [2:0][CW-1:0] w_org_q, w_dir_q;
  logic               w_miss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_valid_q <= 1'b0;
    end else if (en) begin
      w_valid_q <= tdiv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_t_q    <= t_full[CW-1:0];  // a t inside the window fits CW bits
      w_org_q  <= tdiv_side.org;
      w_dir_q  <= tdiv_side.dir;
      w_miss_q <= win_miss;
    end
  end

  // Multiply stage: t * dir on every axis
  logic                   m_valid_q;
  logic [2:0][PROD_W-1:0] m_prod_q;
  logic [2:0][CW-1:0]     m_org_q;
  logic [CW-1:0]          m_t_q;
  logic                   m_miss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= w_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m_prod_q[i] <= PROD_W'($signed(w_t_q) * $signed(w_dir_q[i]));
      end
      m_org_q  <= w_org_q;
      m_t_q    <= w_t_q;
      m_miss_q <= w_miss_q;
    end
  end

  // Point stage: exact hit point, bound tests, texture numerators and spans
  logic signed [PT_W-1:0] pt [3];
  logic signed [PT_W-1:0] pa, pb, alo_e, ahi_e, blo_e, bhi_e, xa, xb;
  logic [1:0][SPAN_W-1:0] tex_x, tex_span;
  tex_side_t              p_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt[i] = PT_W'($signed(m_org_q[i])) + PT_W'($signed(m_prod_q[i][PROD_W-1:FB]));
    end
    unique case (axis_e'(axis_q))
      AX_XY: begin
        pa = pt[0];
        pb = pt[1];
      end
      AX_XZ: begin
        pa = pt[0];
        pb = pt[2];
      end
      default: begin
        pa = pt[1];
        pb = pt[2];
      end
    endcase
    alo_e = PT_W'($signed(a_low_q));
    ahi_e = PT_W'($signed(a_high_q));
    blo_e = PT_W'($signed(b_low_q));
    bhi_e = PT_W'($signed(b_high_q));
    xa    = pa - alo_e;
    xb    = pb - blo_e;
    tex_x[0]    = xa[SPAN_W-1:0];
    tex_x[1]    = xb[SPAN_W-1:0];
    tex_span[0] = {a_high_q[CW-1], a_high_q} - {a_low_q[CW-1], a_low_q};
    tex_span[1] = {b_high_q[CW-1], b_high_q} - {b_low_q[CW-1], b_low_q};
    p_side.miss   = m_miss_q || (pa < alo_e) || (pa > ahi_e) || (pb < blo_e) || (pb > bhi_e);
    p_side.t_hit  = m_t_q;
    for (int i = 0; i < 3; i++) begin
      p_side.pt[i] = sat_coord(pt[i]);
    end
    p_side.zero_a = (tex_span[0] == '0);
    p_side.zero_b = (tex_span[1] == '0);
  end

  logic                  tex_valid;
  logic [1:0][TEX_W-1:0] tex_quot;
  tex_side_t             tex_side;

  rai_texdiv u_texdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m_valid_q),
    .x_i     (tex_x),
    .span_i  (tex_span),
    .side_i  (p_side),
    .valid_o (tex_valid),
    .quot_o  (tex_quot),
    .side_o  (tex_side)
  );

  // Output register: zero every field of a miss
  hit_out_t out_d, out_q;

  always_comb begin
    out_d = '0;
    if (!tex_side.miss) begin
      out_d.hit          = 1'b1;
      out_d.t_hit        = tex_side.t_hit;
      out_d.tex_u        = tex_side.zero_a ? '0 : tex_quot[0];
      out_d.tex_v        = tex_side.zero_b ? '0 : tex_quot[1];
      out_d.point_x      = tex_side.pt[0];
      out_d.point_y      = tex_side.pt[1];
      out_d.point_z      = tex_side.pt[2];
      out_d.normal_axis  = axis_q;
      out_d.hit_material = material_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= tex_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A miss word carries nothing but zeros
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |-> out_data_o.t_hit == '0 && out_data_o.tex_u == '0
      && out_data_o.tex_v == '0 && out_data_o.point_x == '0 && out_data_o.point_y == '0
      && out_data_o.point_z == '0 && out_data_o.hit_material == '0)
    else $error("miss word has nonzero fields");

  // A hit never reports the unused axis code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |-> out_data_o.normal_axis != AX_BAD)
    else $error("hit reported on invalid plane axis");

  // Texture coordinates stay within zero to one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |->
      out_data_o.tex_u <= (TEX_W'(1) << TEX_BITS) && out_data_o.tex_v <= (TEX_W'(1) << TEX_BITS))
    else $error("texture coordinate above one");

  // A stalled output word holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

endmodule

/* test/tb.sv */
// Self-checking testbench for ray_axis_rectangle_intersect_unit: directed and random rays
// against several rectangle settings, each result checked by an in-bench predictor.
// Depends on rai_pkg and the RTL of the block; needs nothing else.
module tb;
  import rai_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam wide_t COORD_MAX = 128'sd2147483647;
  localparam wide_t COORD_MIN = -128'sd2147483648;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  ray_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  hit_out_t    out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i = '0;
  logic [CW-1:0]    cfg_data_i = '0;

  // Shadow of the rectangle registers, updated on every write the block sees
  axis_e              rect_axis;
  logic signed [31:0] rect_offset, rect_a_lo, rect_a_hi, rect_b_lo, rect_b_hi;
  logic [15:0]        rect_material;

  hit_out_t pending_hits[$];
  int       mismatches = 0;
  int       rays_taken = 0;
  int       in_gap_max = 15;   // set to 0 for back-to-back stretches
  int       out_stall_max = 15;

  ray_axis_rectangle_intersect_unit DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // 20-unit period clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [31:0] sat_to_coord(wide_t v);
    if (v > COORD_MAX) return 32'h7fffffff;
    if (v < COORD_MIN) return 32'h80000000;
    return v[31:0];
  endfunction

  // Position across the span in Q1.16; a zero-width side maps to 0
  function automatic logic [TEX_W-1:0] tex_coord(wide_t pv, wide_t lo, wide_t hi);
    wide_t span;
    wide_t q;
    span = hi - lo;
    if (span == 0) return '0;
    q = ((pv - lo) <<< TEX_BITS) / span;
    return q[TEX_W-1:0];
  endfunction

  // Work out the hit word for one ray under the current rectangle settings
  function automatic hit_out_t predict_hit(ray_in_t r);
    hit_out_t h;
    wide_t    org[3], dir[3], pt[3];
    wide_t    t, alo, ahi, blo, bhi;
    int       n, ia, ib;
    h = '0;
    case (rect_axis)
      AX_XY: begin n = 2; ia = 0; ib = 1; end
      AX_XZ: begin n = 1; ia = 0; ib = 2; end
      AX_YZ: begin n = 0; ia = 1; ib = 2; end
      default: return h;
    endcase
    org[0] = r.origin_x; org[1] = r.origin_y; org[2] = r.origin_z;
    dir[0] = r.dir_x;    dir[1] = r.dir_y;    dir[2] = r.dir_z;
    if (dir[n] == 0) return h;
    t = ((wide_t'(rect_offset) - org[n]) <<< FB) / dir[n];
    if (t < wide_t'(r.t_lower) || t > wide_t'(r.t_upper)) return h;
    for (int i = 0; i < 3; i++) pt[i] = org[i] + ((t * dir[i]) >>> FB);
    alo = rect_a_lo; ahi = rect_a_hi; blo = rect_b_lo; bhi = rect_b_hi;
    if (pt[ia] < alo || pt[ia] > ahi || pt[ib] < blo || pt[ib] > bhi) return h;
    h.hit          = 1'b1;
    h.t_hit        = sat_to_coord(t);
    h.tex_u        = tex_coord(pt[ia], alo, ahi);
    h.tex_v        = tex_coord(pt[ib], blo, bhi);
    h.point_x      = sat_to_coord(pt[0]);
    h.point_y      = sat_to_coord(pt[1]);
    h.point_z      = sat_to_coord(pt[2]);
    h.normal_axis  = rect_axis;
    h.hit_material = rect_material;
    return h;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
  endtask

  // Track register writes and accepted rays; queue the predicted word per ray
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_axis     <= AX_XY;
      rect_offset   <= '0;
      rect_a_lo     <= '0;
      rect_a_hi     <= 32'sd65536;
      rect_b_lo     <= '0;
      rect_b_hi     <= 32'sd65536;
      rect_material <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_AXIS:     rect_axis     <= axis_e'(cfg_data_i[1:0]);
          CFG_OFFSET:   rect_offset   <= cfg_data_i;
          CFG_A_LOW:    rect_a_lo     <= cfg_data_i;
          CFG_A_HIGH:   rect_a_hi     <= cfg_data_i;
          CFG_B_LOW:    rect_b_lo     <= cfg_data_i;
          CFG_B_HIGH:   rect_b_hi     <= cfg_data_i;
          CFG_MATERIAL: rect_material <= cfg_data_i[15:0];
          default: ;  // drop writes past the material tag
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        pending_hits.push_back(predict_hit(in_data_i));
        rays_taken++;
      end
    end
  end

  // Compare each delivered word with the oldest prediction, field by field
  always @(posedge clk_i) begin
    hit_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_hits.size() == 0) begin
        report("unexpected word", out_data_o.t_hit, '0);
      end else begin
        want = pending_hits.pop_front();
        if (out_data_o.hit != want.hit) report("hit", out_data_o.hit, want.hit);
        if (out_data_o.t_hit != want.t_hit) report("t_hit", out_data_o.t_hit, want.t_hit);
        if (out_data_o.tex_u != want.tex_u) report("tex_u", out_data_o.tex_u, want.tex_u);
        if (out_data_o.tex_v != want.tex_v) report("tex_v", out_data_o.tex_v, want.tex_v);
        if (out_data_o.point_x != want.point_x)
          report("point_x", out_data_o.point_x, want.point_x);
        if (out_data_o.point_y != want.point_y)
          report("point_y", out_data_o.point_y, want.point_y);
        if (out_data_o.point_z != want.point_z)
          report("point_z", out_data_o.point_z, want.point_z);
        if (out_data_o.normal_axis != want.normal_axis)
          report("normal_axis", out_data_o.normal_axis, want.normal_axis);
        if (out_data_o.hit_material != want.hit_material)
          report("hit_material", out_data_o.hit_material, want.hit_material);
      end
    end
  end

  // Receiver: stall a random number of cycles per word, then take it.
  // Sample at the falling edge so the decision never races the rising edge.
  initial begin
    int  stall;
    bit  seen;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        seen = out_valid_o;
        @(posedge clk_i);
      end while (!seen);
    end
  end

  // Send one ray word: idle a random gap, then hold valid until the word is taken
  task automatic send_ray(ray_in_t r);
    int gap;
    bit taken;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Drop valid, drain every outstanding word, then let the pipe settle
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  task automatic set_rect(axis_e ax, logic [31:0] off, logic [31:0] alo, logic [31:0] ahi,
                          logic [31:0] blo, logic [31:0] bhi, logic [15:0] mat);
    write_reg(CFG_AXIS, 32'(ax));
    write_reg(CFG_OFFSET, off);
    write_reg(CFG_A_LOW, alo);
    write_reg(CFG_A_HIGH, ahi);
    write_reg(CFG_B_LOW, blo);
    write_reg(CFG_B_HIGH, bhi);
    write_reg(CFG_MATERIAL, 32'(mat));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_signed(int unsigned range);
    return $urandom_range(0, 2 * range) - range;
  endfunction

  // Build a ray aimed at a random point of the rectangle, with random content.
  // Rounding of the back-projected origin may still make it miss near an edge.
  function automatic ray_in_t aimed_ray();
    ray_in_t r;
    wide_t   tgt[3], dir[3], t, span;
    int      n, ia, ib;
    case (rect_axis)
      AX_XZ:   begin n = 1; ia = 0; ib = 2; end
      AX_YZ:   begin n = 0; ia = 1; ib = 2; end
      default: begin n = 2; ia = 0; ib = 1; end
    endcase
    span = wide_t'(rect_a_hi) - wide_t'(rect_a_lo);
    tgt[ia] = (span > 0) ? wide_t'(rect_a_lo) + ({$urandom, $urandom} % (span + 1))
                         : wide_t'(rect_a_lo);
    span = wide_t'(rect_b_hi) - wide_t'(rect_b_lo);
    tgt[ib] = (span > 0) ? wide_t'(rect_b_lo) + ({$urandom, $urandom} % (span + 1))
                         : wide_t'(rect_b_lo);
    tgt[n] = rect_offset;
    for (int i = 0; i < 3; i++) dir[i] = $signed(rand_signed(1 << 18));
    if (dir[n] == 0) dir[n] = 1;
    t = ($urandom_range(0, 7) == 0) ? -wide_t'($urandom_range(0, 1 << 20))
                                    : wide_t'($urandom_range(0, 1 << 20));
    r.origin_x = sat_to_coord(tgt[0] - ((t * dir[0]) >>> FB));
    r.origin_y = sat_to_coord(tgt[1] - ((t * dir[1]) >>> FB));
    r.origin_z = sat_to_coord(tgt[2] - ((t * dir[2]) >>> FB));
    r.dir_x = dir[0][31:0];
    r.dir_y = dir[1][31:0];
    r.dir_z = dir[2][31:0];
    r.t_lower = sat_to_coord(t - $urandom_range(0, 4096));
    r.t_upper = sat_to_coord(t + $urandom_range(0, 4096));
    if ($urandom_range(0, 9) == 0) r.t_upper = r.t_lower - 1;  // reversed window
    return r;
  endfunction

  function automatic ray_in_t noise_ray();
    ray_in_t r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 3) == 0) r.dir_z = '0;
    return r;
  endfunction

  // Mostly aimed rays, the rest pure noise; alternate idling and back-to-back stretches
  task automatic random_rays(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        in_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 15;
        out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      end
      send_ray(($urandom_range(0, 9) < 8) ? aimed_ray() : noise_ray());
    end
    in_gap_max    = 15;
    out_stall_max = 15;
  endtask

  function automatic ray_in_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                     int tl, int tu);
    ray_in_t r;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    r.t_lower = tl; r.t_upper = tu;
    return r;
  endfunction

  // Reset rectangle: unit square in z = 0. Corners, window edges, zero direction,
  // reversed window and field extremes.
  task automatic test_directed;
    send_ray(mk_ray(32768, 32768, 65536, 0, 0, -65536, 0, 65536));       // center hit
    send_ray(mk_ray(0, 0, 65536, 0, 0, -65536, 65536, 65536));           // corner, t on edges
    send_ray(mk_ray(65536, 65536, 65536, 0, 0, -65536, 0, 65536));       // far corner
    send_ray(mk_ray(65537, 0, 65536, 0, 0, -65536, 0, 65536));           // just outside a
    send_ray(mk_ray(0, -1, 65536, 0, 0, -65536, 0, 65536));              // just outside b
    send_ray(mk_ray(32768, 32768, 65536, 0, 0, 0, 0, 65536));            // zero normal dir
    send_ray(mk_ray(32768, 32768, 65536, 0, 0, -65536, 65537, 65536));   // reversed window
    send_ray(mk_ray(32768, 32768, 65536, 0, 0, -65536, 65537, 131072));  // t below window
    send_ray(mk_ray(32768, 32768, 65536, 0, 0, -65536, 0, 65535));       // t above window
    send_ray(mk_ray(32768, 32768, -65536, 0, 0, 65536, 0, 65536));       // from below
    send_ray(mk_ray(0, 0, 131072, 32768, 32768, -131072, 0, 65536));     // oblique
    send_ray(mk_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                    32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send_ray(mk_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                    32'h80000000, 32'h80000000, 32'h80000000));
    send_ray(mk_ray(0, 0, 32'h7fffffff, 0, 0, -1, 32'h80000000, 32'h7fffffff)); // huge t
    send_ray(mk_ray(0, 0, 32'h80000000, 0, 0, 1, 32'h80000000, 32'h7fffffff));
    send_ray(mk_ray(0, 0, 65536, 32'h7fffffff, 32'h80000000, -65536, 0, 65536)); // sat point
    send_ray(mk_ray(-1, -1, -1, -1, -1, -1, -1, -1));
    send_ray('0);
    drain;
  endtask

  // Each plane orientation with its own rectangle, random offsets on two, both material extremes
  task automatic test_planes;
    set_rect(AX_XZ, rand_signed(1 << 20), -32'sd65536, 32'sd131072, -32'sd262144,
             32'sd65536, 16'hffff);
    random_rays(300);
    drain;
    set_rect(AX_YZ, rand_signed(1 << 20), 32'sd0, 32'sd1 << 20, -32'sd1 << 20,
             32'sd0, 16'h5a3c);
    random_rays(300);
    drain;
    set_rect(AX_XY, -32'sd1 << 22, -32'sd1 << 24, 32'sd1 << 24, 32'sd100, 32'sd300, 16'h0);
    random_rays(300);
    drain;
  endtask

  // Full-range bounds and offsets at both extremes
  task automatic test_extremes;
    set_rect(AX_YZ, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
             16'hffff);
    random_rays(150);
    drain;
    set_rect(AX_XZ, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
             16'h0001);
    random_rays(150);
    drain;
  endtask

  // Zero-width side, reversed bounds, the unused axis code and a dropped index
  task automatic test_degenerate;
    set_rect(AX_XY, 32'sd65536, 32'sd4096, 32'sd4096, -32'sd65536, 32'sd65536, 16'h00ff);
    random_rays(100);
    drain;
    set_rect(AX_XZ, 32'sd0, 32'sd65536, 32'sd0, 32'sd0, 32'sd65536, 16'h1234);
    random_rays(50);
    drain;
    set_rect(AX_BAD, 32'sd0, -32'sd65536, 32'sd65536, -32'sd65536, 32'sd65536, 16'h7777);
    random_rays(50);
    drain;
    set_rect(AX_XY, 32'sd0, -32'sd65536, 32'sd65536, -32'sd65536, 32'sd65536, 16'h2222);
    write_reg(CFG_NONE, 32'hffffffff);  // must leave every register alone
    cfg_we_i <= 1'b0;
    random_rays(100);
    drain;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed;
    test_planes;
    test_extremes;
    test_degenerate;
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #40000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
